/* rtl/core/hbet_pkg.sv */
package hbet_pkg;

	localparam int TableDepth  = 32;
	localparam int MaxKeyBytes = 8;
	localparam int MaxOut      = 32;
	localparam int IdxW        = $clog2(TableDepth);
	localparam int CntW        = 7;
	localparam int QDepth      = 2;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_REMALL = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2,
		ST_INVALID  = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [63:0] key_bytes;
		logic [3:0]  key_len;
		logic [30:0] rec_page;
		logic [15:0] rec_slot;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        inserted;
		logic [30:0] match_page;
		logic [15:0] match_slot;
		logic [6:0]  num_removed;
		logic [6:0]  num_held;
		logic        last;
	} rsp_t;

	// classified request passed from front to back
	typedef struct packed {
		cmd_t        cmd;
		logic        invalid;
		logic [63:0] key;
		logic [3:0]  key_len;
		logic [30:0] page;
		logic [15:0] slot;
	} work_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_READ,
		BK_CHECK,
		BK_MOVE,
		BK_DONE
	} bk_state_t;

	function automatic logic [63:0] key_mask(input logic [3:0] len);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++)
			if (4'(b) < len) m[b*8 +: 8] = 8'hFF;
		return m;
	endfunction

endpackage

/* rtl/core/hash_bucket_entry_table.sv */
// Hash bucket entry table: up to 32 (key, record) entries.
// Request channel: cmd/key/record on req, accepted at a rising edge with
// start high and busy low. One request is processed at a time; busy stays
// high until its final result has been sent.
// Result channel: strobe marks each result on rsp for one cycle; the
// receiver cannot stall. A lookup gives one result per match, the final
// one marked last; all other commands give one result with last set.
// The back end reads each stored entry through a registered table read,
// a read state then a check state per entry, and each removal that is not
// of the last entry adds a compaction move.
// An insert that finds its duplicate, or a remove-one that finds its match,
// ends its scan early; an invalid request answers without a scan.
// The next request can be accepted at the edge the final strobe rises,
// and later after a lookup with matches, once its held final result is sent.
// Reset clears the fill count; entry contents are not cleared.
module hash_bucket_entry_table (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  hbet_pkg::req_t   req,
	output logic             strobe,
	output hbet_pkg::rsp_t   rsp
);

	logic             q_valid, q_pop, back_idle, bk_done;
	hbet_pkg::work_t  q_data;
	hbet_pkg::rsp_t   bk_rsp;
	hbet_pkg::rsp_t   held_q, held_fin, rsp_d;
	logic             held_v_q, held_v_d, held_ld, strobe_d;

	hbet_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.back_idle(back_idle && !held_v_q), .busy(busy),
		.q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
	);

	hbet_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_data(q_data),
		.q_pop(q_pop), .idle(back_idle), .done(bk_done), .rsp(bk_rsp)
	);

	// lookup matches are held one result deep so last can be set on the final one
	always_comb begin
		held_fin      = held_q;
		held_fin.last = 1'b1;
		strobe_d = 1'b0;
		held_v_d = held_v_q;
		held_ld  = 1'b0;
		rsp_d    = held_q;
		if (bk_done && !bk_rsp.last) begin
			strobe_d = held_v_q;
			held_v_d = 1'b1;
			held_ld  = 1'b1;
		end else if (bk_done) begin
			strobe_d = 1'b1;
			held_v_d = 1'b0;
			rsp_d    = bk_rsp;
		end else if (held_v_q && back_idle) begin
			strobe_d = 1'b1;
			held_v_d = 1'b0;
			rsp_d    = held_fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_v_q <= 1'b0;
			strobe   <= 1'b0;
		end else begin
			held_v_q <= held_v_d;
			strobe   <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		if (held_ld) held_q <= bk_rsp;
		if (strobe_d) rsp <= rsp_d;
	end

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && rsp.last) |-> !held_v_q) else $error("held result after last");
	a_held_busy: assert property (@(posedge clk) disable iff (!arst_n)
		held_v_q |-> busy) else $error("request taken while a result is held");
	a_match_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(bk_done && !bk_rsp.last) |-> !back_idle) else $error("match while back idle");

endmodule

/* rtl/core/hbet_front.sv */
module hbet_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  hbet_pkg::req_t   req,
	input  logic             back_idle,
	output logic             busy,
	output logic             q_valid,
	output hbet_pkg::work_t  q_data,
	input  logic             q_pop
);

	localparam int PtrW = $clog2(hbet_pkg::QDepth);

	hbet_pkg::work_t        q_mem [hbet_pkg::QDepth];
	logic [PtrW-1:0]        wr_ptr_q, rd_ptr_q;
	logic [PtrW:0]          count_q;
	logic                   take;
	hbet_pkg::work_t        cls;

	// one request in flight at a time: table state depends on prior request
	assign busy    = (count_q != '0) || !back_idle;
	assign take    = start && !busy;
	assign q_valid = (count_q != '0);
	assign q_data  = q_mem[rd_ptr_q];

	// classify the request
	always_comb begin
		cls.cmd     = hbet_pkg::cmd_t'(req.cmd);
		cls.key     = req.key_bytes & hbet_pkg::key_mask(req.key_len);
		cls.key_len = req.key_len;
		cls.page    = req.rec_page;
		cls.slot    = req.rec_slot;
		cls.invalid = (req.key_len > 4'(hbet_pkg::MaxKeyBytes)) ||
			(hbet_pkg::cmd_t'(req.cmd) == hbet_pkg::CMD_INSERT && req.rec_page == '0);
	end

	always_ff @(posedge clk) begin
		if (take) q_mem[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (take) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (q_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (PtrW+1)'(take) - (PtrW+1)'(q_pop);
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PtrW+1)'(hbet_pkg::QDepth)) else $error("queue overflow");
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> busy) else $error("busy not raised after take");

endmodule

/* rtl/core/hbet_back.sv */
module hbet_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  hbet_pkg::work_t  q_data,
	output logic             q_pop,
	output logic             idle,
	output logic             done,
	output hbet_pkg::rsp_t   rsp
);

	localparam int EntW = 64 + 4 + 31 + 16;
	localparam int IdxW = hbet_pkg::IdxW;
	localparam int CntW = hbet_pkg::CntW;

	logic [EntW-1:0]           mem [hbet_pkg::TableDepth];
	logic [EntW-1:0]           rd_q;
	hbet_pkg::bk_state_t       state_q, state_d;
	hbet_pkg::work_t           w_q;
	logic [CntW-1:0]           fill_q, fill_d;
	logic [CntW-1:0]           idx_q, idx_d;
	logic [CntW-1:0]           rem_q, rem_d;
	logic [5:0]                nout_q, nout_d;
	logic [IdxW-1:0]           rd_addr;
	logic                      wr_en;
	logic [IdxW-1:0]           wr_addr;
	logic [EntW-1:0]           wr_data;
	logic                      key_hit, rec_hit;
	logic                      done_d;
	hbet_pkg::rsp_t            rsp_d;
	logic                      latch_w;

	// entry layout: key, key length, page, slot
	assign key_hit = rd_q[EntW-1 -: 64] == w_q.key && rd_q[47 +: 4] == w_q.key_len;
	assign rec_hit = rd_q[16 +: 31] == w_q.page && rd_q[15:0] == w_q.slot;

	// table memory, one read and one write port
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hbet_pkg::BK_IDLE;
			fill_q  <= '0;
			idx_q   <= '0;
			rem_q   <= '0;
			nout_q  <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			idx_q   <= idx_d;
			rem_q   <= rem_d;
			nout_q  <= nout_d;
			done    <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (latch_w) w_q <= q_data;
		if (done_d) rsp <= rsp_d;
	end

	// sequencer: scan each entry; read address issued, then checked
	always_comb begin
		state_d = state_q;
		fill_d  = fill_q;
		idx_d   = idx_q;
		rem_d   = rem_q;
		nout_d  = nout_q;
		done_d  = 1'b0;
		rsp_d   = '0;
		q_pop   = 1'b0;
		latch_w = 1'b0;
		wr_en   = 1'b0;
		wr_addr = idx_q[IdxW-1:0];
		wr_data = {w_q.key, w_q.key_len, w_q.page, w_q.slot};
		rd_addr = idx_q[IdxW-1:0];
		unique case (state_q)
			hbet_pkg::BK_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					latch_w = 1'b1;
					idx_d   = '0;
					rem_d   = '0;
					nout_d  = '0;
					state_d = hbet_pkg::BK_READ;
				end
			end
			hbet_pkg::BK_READ: begin
				if (w_q.invalid) begin
					done_d = 1'b1;
					rsp_d.status = hbet_pkg::ST_INVALID;
					rsp_d.num_held = fill_q;
					rsp_d.last = 1'b1;
					state_d = hbet_pkg::BK_IDLE;
				end else if (idx_q >= fill_q ||
						(w_q.cmd == hbet_pkg::CMD_LOOKUP && nout_q == 6'(hbet_pkg::MaxOut))) begin
					state_d = hbet_pkg::BK_DONE;
				end else begin
					rd_addr = idx_q[IdxW-1:0];
					state_d = hbet_pkg::BK_CHECK;
				end
			end
			hbet_pkg::BK_CHECK: begin
				state_d = hbet_pkg::BK_READ;
				idx_d   = idx_q + 1'b1;
				unique case (w_q.cmd) inside
					hbet_pkg::CMD_INSERT: begin
						if (key_hit && rec_hit) begin
							done_d = 1'b1;
							rsp_d.status = hbet_pkg::ST_OK;
							rsp_d.num_held = fill_q;
							rsp_d.last = 1'b1;
							state_d = hbet_pkg::BK_IDLE;
						end
					end
					hbet_pkg::CMD_LOOKUP: begin
						if (key_hit) begin
							done_d = 1'b1;
							rsp_d.status = hbet_pkg::ST_OK;
							rsp_d.match_page = rd_q[16 +: 31];
							rsp_d.match_slot = rd_q[15:0];
							rsp_d.num_held = fill_q;
							nout_d = nout_q + 1'b1;
						end
					end
					hbet_pkg::CMD_REMOVE, hbet_pkg::CMD_REMALL: begin
						if (key_hit && (w_q.cmd == hbet_pkg::CMD_REMALL || rec_hit)) begin
							rem_d  = rem_q + 1'b1;
							fill_d = fill_q - 1'b1;
							idx_d  = idx_q;
							if (idx_q != fill_q - 1'b1) begin
								rd_addr = IdxW'(fill_q - 1'b1);
								state_d = hbet_pkg::BK_MOVE;
							end else state_d = hbet_pkg::BK_READ;
							if (w_q.cmd == hbet_pkg::CMD_REMOVE && idx_q == fill_q - 1'b1)
								state_d = hbet_pkg::BK_DONE;
						end
					end
				endcase
			end
			hbet_pkg::BK_MOVE: begin
				// rd_q holds last entry; write it into the hole, then recheck the hole (remove-all) or finish (remove-one)
				wr_en   = 1'b1;
				wr_data = rd_q;
				state_d = (w_q.cmd == hbet_pkg::CMD_REMOVE) ? hbet_pkg::BK_DONE
					: hbet_pkg::BK_READ;
			end
			hbet_pkg::BK_DONE: begin
				done_d = 1'b1;
				rsp_d.num_held = fill_q;
				rsp_d.last = 1'b1;
				state_d = hbet_pkg::BK_IDLE;
				unique case (w_q.cmd) inside
					hbet_pkg::CMD_INSERT: begin
						if (fill_q >= CntW'(hbet_pkg::TableDepth))
							rsp_d.status = hbet_pkg::ST_FULL;
						else begin
							wr_en = 1'b1;
							wr_addr = fill_q[IdxW-1:0];
							fill_d = fill_q + 1'b1;
							rsp_d.status = hbet_pkg::ST_OK;
							rsp_d.inserted = 1'b1;
							rsp_d.num_held = fill_q + 1'b1;
						end
					end
					hbet_pkg::CMD_LOOKUP: begin
						if (nout_q == '0) rsp_d.status = hbet_pkg::ST_NOTFOUND;
						else begin
							done_d = 1'b0;
						end
					end
					hbet_pkg::CMD_REMOVE, hbet_pkg::CMD_REMALL: begin
						rsp_d.status = (rem_q == '0) ? hbet_pkg::ST_NOTFOUND
							: hbet_pkg::ST_OK;
						rsp_d.num_removed = rem_q;
					end
				endcase
			end
			default: state_d = hbet_pkg::BK_IDLE;
		endcase
	end

	assign idle = (state_q == hbet_pkg::BK_IDLE);

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CntW'(hbet_pkg::TableDepth)) else $error("fill count out of range");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == hbet_pkg::BK_IDLE) else $error("pop while busy");
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.last) |=> !done) else $error("result after last");

endmodule

/* verif/hbet_checker.sv */
module hbet_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  hbet_pkg::req_t req,
	input  logic           strobe,
	input  hbet_pkg::rsp_t rsp,
	output int             fail_count,
	output int             pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// shadow copy of the table
	logic [63:0] tbl_key [hbet_pkg::TableDepth];
	logic [3:0]  tbl_len [hbet_pkg::TableDepth];
	logic [30:0] tbl_page [hbet_pkg::TableDepth];
	logic [15:0] tbl_slot [hbet_pkg::TableDepth];
	int          tbl_fill;

	hbet_pkg::rsp_t expected_rsps[$];

	int n_hits, n_full, n_invalid, n_multi;

	assign pending = expected_rsps.size();

	function automatic hbet_pkg::rsp_t mk_rsp(logic [1:0] st, logic ins, logic [30:0] pg,
			logic [15:0] sl, int removed, logic lst);
		hbet_pkg::rsp_t r;
		r.status = st;
		r.inserted = ins;
		r.match_page = pg;
		r.match_slot = sl;
		r.num_removed = 7'(removed);
		r.num_held = 7'(tbl_fill);
		r.last = lst;
		return r;
	endfunction

	function automatic void add_rsp(hbet_pkg::rsp_t r);
		expected_rsps.insert(expected_rsps.size(), r);
	endfunction

	function automatic void drop_entry(int i);
		int lx;
		lx = tbl_fill - 1;
		tbl_key[i] = tbl_key[lx];
		tbl_len[i] = tbl_len[lx];
		tbl_page[i] = tbl_page[lx];
		tbl_slot[i] = tbl_slot[lx];
		tbl_fill = lx;
	endfunction

	// apply one request to the shadow table and queue its results
	function automatic void predict_request(hbet_pkg::req_t q);
		logic [63:0] k;
		logic        eq;
		int          i, n, removed;
		bit          done;
		done = 0;
		n = 0;
		removed = 0;
		if (q.key_len > 4'(hbet_pkg::MaxKeyBytes)) begin
			n_invalid++;
			add_rsp(mk_rsp(hbet_pkg::ST_INVALID, 0, 0, 0, 0, 1));
			return;
		end
		k = '0;
		for (int b = 0; b < 8; b++)
			if (b < q.key_len) k[b*8 +: 8] = q.key_bytes[b*8 +: 8];
		case (hbet_pkg::cmd_t'(q.cmd))
			hbet_pkg::CMD_INSERT: begin
				if (q.rec_page == 0) begin
					n_invalid++;
					add_rsp(mk_rsp(hbet_pkg::ST_INVALID, 0, 0, 0, 0, 1));
					return;
				end
				for (i = 0; i < tbl_fill; i++)
					if (!done && tbl_len[i] == q.key_len && tbl_key[i] == k &&
							tbl_page[i] == q.rec_page && tbl_slot[i] == q.rec_slot)
						done = 1;
				if (done) add_rsp(mk_rsp(hbet_pkg::ST_OK, 0, 0, 0, 0, 1));
				else if (tbl_fill >= hbet_pkg::TableDepth) begin
					n_full++;
					add_rsp(mk_rsp(hbet_pkg::ST_FULL, 0, 0, 0, 0, 1));
				end else begin
					tbl_key[tbl_fill] = k;
					tbl_len[tbl_fill] = q.key_len;
					tbl_page[tbl_fill] = q.rec_page;
					tbl_slot[tbl_fill] = q.rec_slot;
					tbl_fill++;
					add_rsp(mk_rsp(hbet_pkg::ST_OK, 1, 0, 0, 0, 1));
				end
			end
			hbet_pkg::CMD_LOOKUP: begin
				for (i = 0; i < tbl_fill && n < hbet_pkg::MaxOut; i++)
					if (tbl_len[i] == q.key_len && tbl_key[i] == k) begin
						add_rsp(mk_rsp(hbet_pkg::ST_OK, 0, tbl_page[i], tbl_slot[i], 0, 0));
						n++;
					end
				if (n == 0) add_rsp(mk_rsp(hbet_pkg::ST_NOTFOUND, 0, 0, 0, 0, 1));
				else begin
					expected_rsps[$].last = 1;
					n_hits++;
					if (n > 1) n_multi++;
				end
			end
			default: begin
				i = 0;
				while (i < tbl_fill && !done) begin
					eq = tbl_len[i] == q.key_len && tbl_key[i] == k;
					if (hbet_pkg::cmd_t'(q.cmd) == hbet_pkg::CMD_REMOVE)
						eq = eq && tbl_page[i] == q.rec_page && tbl_slot[i] == q.rec_slot;
					if (!eq) i++;
					else begin
						drop_entry(i);
						removed++;
						if (hbet_pkg::cmd_t'(q.cmd) == hbet_pkg::CMD_REMOVE) done = 1;
					end
				end
				if (removed == 0)
					add_rsp(mk_rsp(hbet_pkg::ST_NOTFOUND, 0, 0, 0, 0, 1));
				else
					add_rsp(mk_rsp(hbet_pkg::ST_OK, 0, 0, 0, removed, 1));
			end
		endcase
	endfunction

	// watch both channels and compare
	always @(posedge clk or negedge arst_n) begin
		hbet_pkg::rsp_t e;
		if (!arst_n) begin
			tbl_fill = 0;
			fail_count = 0;
			n_hits = 0; n_full = 0; n_invalid = 0; n_multi = 0;
			expected_rsps.delete();
		end else begin
			if (strobe) begin
				if (expected_rsps.size() == 0) begin
					$error("result with none expected: %p", rsp);
					fail_count++;
				end else begin
					e = expected_rsps.pop_front();
					if (rsp.status !== e.status) begin
						$error("status exp %0d got %0d", e.status, rsp.status); fail_count++;
					end
					if (rsp.inserted !== e.inserted) begin
						$error("inserted exp %0d got %0d", e.inserted, rsp.inserted);
						fail_count++;
					end
					if (rsp.match_page !== e.match_page) begin
						$error("match_page exp %0h got %0h", e.match_page, rsp.match_page);
						fail_count++;
					end
					if (rsp.match_slot !== e.match_slot) begin
						$error("match_slot exp %0h got %0h", e.match_slot, rsp.match_slot);
						fail_count++;
					end
					if (rsp.num_removed !== e.num_removed) begin
						$error("num_removed exp %0d got %0d", e.num_removed,
							rsp.num_removed);
						fail_count++;
					end
					if (rsp.num_held !== e.num_held) begin
						$error("num_held exp %0d got %0d", e.num_held, rsp.num_held);
						fail_count++;
					end
					if (rsp.last !== e.last) begin
						$error("last exp %0d got %0d", e.last, rsp.last); fail_count++;
					end
				end
			end
			if (start && !busy) predict_request(req);
		end
	end
endmodule

/* verif/hash_bucket_entry_table_tb.sv */
module hash_bucket_entry_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk, arst_n, start, busy, strobe;
	hbet_pkg::req_t req;
	hbet_pkg::rsp_t rsp;
	int   fail_count, pending;

	// small pools so keys and records collide often
	logic [63:0] key_pool [6];
	logic [30:0] page_pool [4];

	hash_bucket_entry_table dut (.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .strobe(strobe), .rsp(rsp));

	hbet_checker chk (.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.strobe(strobe), .rsp(rsp), .fail_count(fail_count), .pending(pending));

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// one request: drive, wait for acceptance, then an optional gap
	task automatic send_request(logic [1:0] c, logic [63:0] k, logic [3:0] l,
			logic [30:0] p, logic [15:0] s, bit gap);
		int           g;
		logic [127:0] junk;
		req <= '{cmd: c, key_bytes: k, key_len: l, rec_page: p, rec_slot: s};
		start <= 1;
		do @(posedge clk); while (busy);
		if (gap) begin
			g = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
			if (g > 0) begin
				junk = {$urandom, $urandom, $urandom, $urandom};
				start <= 0;
				req <= junk[$bits(hbet_pkg::req_t)-1:0];
				repeat (g) @(posedge clk);
			end
		end
	endtask

	task automatic send_random();
		logic [1:0]  c;
		logic [63:0] k;
		logic [3:0]  l;
		logic [30:0] p;
		logic [15:0] s;
		int          r;
		r = $urandom_range(0, 99);
		c = (r < 45) ? hbet_pkg::CMD_INSERT : (r < 75) ? hbet_pkg::CMD_LOOKUP
			: (r < 90) ? hbet_pkg::CMD_REMOVE : hbet_pkg::CMD_REMALL;
		if ($urandom_range(0, 9) < 8) begin
			k = key_pool[$urandom_range(0, 5)];
			l = 4'($urandom_range(0, 8));
			p = page_pool[$urandom_range(0, 3)];
			s = 16'($urandom_range(0, 3));
		end else begin
			k = {$urandom, $urandom};
			l = 4'($urandom);
			p = 31'($urandom);
			s = 16'($urandom);
		end
		send_request(c, k, l, p, s, 1);
	endtask

	initial begin
		start = 0;
		req = '0;
		arst_n = 0;
		key_pool = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF,
			64'hA5A5_5A5A_0000_0011, 64'h8000_0000_0000_0001, 64'h0000_0000_0000_0042};
		page_pool = '{31'h1, 31'h7FFF_FFFF, 31'h1234, 31'h2};
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: special cases and field extremes
		send_request(hbet_pkg::CMD_LOOKUP, 64'h0, 4'd0, 31'h0, 16'h0, 0);
		send_request(hbet_pkg::CMD_INSERT, 64'hFF, 4'd15, 31'h5, 16'h1, 0);
		send_request(hbet_pkg::CMD_INSERT, 64'h11, 4'd9, 31'h5, 16'h1, 0);
		send_request(hbet_pkg::CMD_INSERT, 64'h11, 4'd1, 31'h0, 16'h1, 0);
		send_request(hbet_pkg::CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 31'h7FFF_FFFF,
			16'hFFFF, 0);
		send_request(hbet_pkg::CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 31'h7FFF_FFFF,
			16'hFFFF, 0);
		send_request(hbet_pkg::CMD_INSERT, 64'hDEAD_00AB, 4'd1, 31'h1, 16'h0, 0);
		send_request(hbet_pkg::CMD_INSERT, 64'h00AB, 4'd1, 31'h2, 16'h0, 0);
		send_request(hbet_pkg::CMD_INSERT, 64'h0, 4'd0, 31'h3, 16'h7, 0);
		send_request(hbet_pkg::CMD_LOOKUP, 64'hFFFF_FF00_00AB, 4'd1, 31'h7FFF_FFFF,
			16'hFFFF, 0);
		send_request(hbet_pkg::CMD_LOOKUP, 64'h0, 4'd0, 31'h0, 16'h0, 0);
		send_request(hbet_pkg::CMD_REMOVE, 64'hAB, 4'd1, 31'h9, 16'h0, 0);
		send_request(hbet_pkg::CMD_REMOVE, 64'hAB, 4'd1, 31'h1, 16'h0, 0);
		send_request(hbet_pkg::CMD_REMOVE, 64'h0, 4'd0, 31'h0, 16'h0, 0);
		send_request(hbet_pkg::CMD_REMALL, 64'hAB, 4'd1, 31'h0, 16'h0, 0);
		send_request(hbet_pkg::CMD_REMALL, 64'hAB, 4'd1, 31'h0, 16'h0, 0);
		// fill the table with one key on top of the two entries left, then overflow and duplicate-when-full
		for (int i = 0; i < hbet_pkg::TableDepth; i++)
			send_request(hbet_pkg::CMD_INSERT, 64'h42, 4'd1, 31'h10, 16'(i), 0);
		send_request(hbet_pkg::CMD_INSERT, 64'h43, 4'd1, 31'h10, 16'h0, 0);
		send_request(hbet_pkg::CMD_INSERT, 64'h42, 4'd1, 31'h10, 16'h3, 0);
		send_request(hbet_pkg::CMD_LOOKUP, 64'h42, 4'd1, 31'h0, 16'h0, 0);
		send_request(hbet_pkg::CMD_REMALL, 64'h42, 4'd1, 31'h0, 16'h0, 0);
		start <= 0;
		while (pending > 0) @(posedge clk);

		// random phase; pause for a full drain now and then
		for (int n = 0; n < 270; n++) begin
			send_random();
			if (n % 100 == 50) begin
				start <= 0;
				while (pending > 0) @(posedge clk);
			end
		end
		start <= 0;
		while (pending > 0) @(posedge clk);
		repeat (150) @(posedge clk);

		$display("Covered: %0d lookup hits (%0d multi), %0d table-full, %0d invalid results",
			chk.n_hits, chk.n_multi, chk.n_full, chk.n_invalid);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
